>>> hdl/abd_pkg.sv
// Shared types, constants and register map of the ambient backlight dimmer.
`timescale 1ns / 1ps

package abd_pkg;

  localparam int unsigned COUNT_WIDTH_DEF    = 16;
  localparam int unsigned DUTY_FRAC_BITS_DEF = 15;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned WEIGHT_W   = 9;
  localparam int unsigned SPAN_W     = 5;
  localparam int unsigned DUTY_W     = 16;
  localparam int unsigned HOLD_W     = 8;
  localparam int unsigned FRAC_W     = 8;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BRIGHT_LIMIT  = 3'd0,
    REG_FULL_LIMIT    = 3'd1,
    REG_DIM_OFFSET    = 3'd2,
    REG_DIM_SPAN_LOG2 = 3'd3,
    REG_MIN_DUTY      = 3'd4,
    REG_BRIGHT_HOLD   = 3'd5,
    REG_SMOOTH_WEIGHT = 3'd6
  } reg_idx_t;

  typedef enum logic [1:0] {
    MODE_RAMP = 2'd0,
    MODE_FULL = 2'd1,
    MODE_DARK = 2'd2
  } drive_mode_t;

  typedef struct packed {
    logic [15:0]         bright_limit;
    logic [15:0]         full_limit;
    logic [15:0]         dim_offset;
    logic [SPAN_W-1:0]   dim_span_log2;
    logic [DUTY_W-1:0]   min_duty;
    logic [HOLD_W-1:0]   bright_hold;
    logic [WEIGHT_W-1:0] smooth_weight;
  } cfg_t;

  localparam logic [15:0]         RST_BRIGHT_LIMIT  = 16'd26624;
  localparam logic [15:0]         RST_FULL_LIMIT    = 16'd1280;
  localparam logic [15:0]         RST_DIM_OFFSET    = 16'd128;
  localparam logic [SPAN_W-1:0]   RST_DIM_SPAN_LOG2 = 5'd10;
  localparam logic [DUTY_W-1:0]   RST_MIN_DUTY      = 16'd2621;
  localparam logic [HOLD_W-1:0]   RST_BRIGHT_HOLD   = 8'd24;
  localparam logic [WEIGHT_W-1:0] RST_SMOOTH_WEIGHT = 9'd87;

endpackage

>>> hdl/abd_cfg_regs.sv
// Configuration register file of the ambient backlight dimmer.
`timescale 1ns / 1ps

module abd_cfg_regs (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [abd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [abd_pkg::CFG_DATA_W-1:0] cfg_data,
  output abd_pkg::cfg_t                  cfg
);
  import abd_pkg::*;

  cfg_t cfg_r;

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.bright_limit  <= RST_BRIGHT_LIMIT;
      cfg_r.full_limit    <= RST_FULL_LIMIT;
      cfg_r.dim_offset    <= RST_DIM_OFFSET;
      cfg_r.dim_span_log2 <= RST_DIM_SPAN_LOG2;
      cfg_r.min_duty      <= RST_MIN_DUTY;
      cfg_r.bright_hold   <= RST_BRIGHT_HOLD;
      cfg_r.smooth_weight <= RST_SMOOTH_WEIGHT;
    end else if (cfg_valid && cfg_ready) begin
      case (reg_idx_t'(cfg_index))
        REG_BRIGHT_LIMIT:  cfg_r.bright_limit  <= cfg_data;
        REG_FULL_LIMIT:    cfg_r.full_limit    <= cfg_data;
        REG_DIM_OFFSET:    cfg_r.dim_offset    <= cfg_data;
        REG_DIM_SPAN_LOG2: cfg_r.dim_span_log2 <= cfg_data[SPAN_W-1:0];
        REG_MIN_DUTY:      cfg_r.min_duty      <= cfg_data[DUTY_W-1:0];
        REG_BRIGHT_HOLD:   cfg_r.bright_hold   <= cfg_data[HOLD_W-1:0];
        REG_SMOOTH_WEIGHT: cfg_r.smooth_weight <= cfg_data[WEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

>>> hdl/abd_blend.sv
// Bit-serial exponential blend unit: (x*w + old*(256-w) + 128) >> 8.
`timescale 1ns / 1ps

module abd_blend #(
  parameter int unsigned AVG_W = abd_pkg::COUNT_WIDTH_DEF + abd_pkg::FRAC_W
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [AVG_W-1:0]             x_in,
  input  logic [AVG_W-1:0]             old_in,
  input  logic [abd_pkg::WEIGHT_W-1:0] weight,
  output logic                         done,
  output logic [AVG_W-1:0]             result
);
  import abd_pkg::*;

  // Two guard bits above the scaled old value hold the signed difference terms.
  localparam int unsigned PROD_W = AVG_W + FRAC_W + 2;
  localparam int unsigned STEP_W = $clog2(WEIGHT_W + 1);

  logic [PROD_W-1:0]   acc_r, acc_nxt;
  logic [PROD_W-1:0]   add_r, add_nxt;
  logic [WEIGHT_W-1:0] w_r, w_nxt, w_sat;
  logic [STEP_W-1:0]   step_r, step_nxt;
  logic                busy_r, busy_nxt;
  logic                done_r, done_nxt;

  // The product is rewritten as old*256 + (x - old)*w, so one weight bit is
  // consumed per cycle with a single add of the shifted difference.
  always_comb begin
    w_sat    = (weight > WEIGHT_W'(256)) ? WEIGHT_W'(256) : weight;
    acc_nxt  = acc_r;
    add_nxt  = add_r;
    w_nxt    = w_r;
    step_nxt = step_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      acc_nxt  = {2'b00, old_in, {FRAC_W{1'b0}}} + PROD_W'(128);
      add_nxt  = PROD_W'(x_in) - PROD_W'(old_in);
      w_nxt    = w_sat;
      step_nxt = STEP_W'(WEIGHT_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (w_r[0]) begin
        acc_nxt = acc_r + add_r;
      end
      add_nxt  = {add_r[PROD_W-2:0], 1'b0};
      w_nxt    = {1'b0, w_r[WEIGHT_W-1:1]};
      step_nxt = step_r - STEP_W'(1);
      if (step_r == STEP_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    add_r <= add_nxt;
    w_r   <= w_nxt;
  end

  assign done   = done_r;
  assign result = acc_r[AVG_W+FRAC_W-1:FRAC_W];

endmodule

>>> hdl/abd_ramp.sv
// Clamped linear dimming ramp computed from the light average.
`timescale 1ns / 1ps

module abd_ramp #(
  parameter int unsigned AVG_W          = abd_pkg::COUNT_WIDTH_DEF + abd_pkg::FRAC_W,
  parameter int unsigned DUTY_FRAC_BITS = abd_pkg::DUTY_FRAC_BITS_DEF
) (
  input  logic [AVG_W-1:0]           avg,
  input  logic [15:0]                dim_offset,
  input  logic [abd_pkg::SPAN_W-1:0] dim_span_log2,
  input  logic [abd_pkg::DUTY_W-1:0] min_duty,
  output logic [abd_pkg::DUTY_W-1:0] ramp
);
  import abd_pkg::*;

  localparam int unsigned EXT_W     = (AVG_W > 24) ? AVG_W : 24;
  localparam int unsigned SH_W      = EXT_W + DUTY_FRAC_BITS;
  localparam int unsigned FULL_INT  = (DUTY_FRAC_BITS >= 16) ? 65535 : (1 << DUTY_FRAC_BITS);
  localparam logic [DUTY_W-1:0] DUTY_FULL = DUTY_W'(FULL_INT);

  logic [EXT_W-1:0]  avg_ext, base_ext, diff;
  logic [SH_W-1:0]   shifted;
  logic [5:0]        amount;
  logic [DUTY_W-1:0] low;

  always_comb begin
    avg_ext  = EXT_W'(avg);
    base_ext = EXT_W'({dim_offset, {FRAC_W{1'b0}}});
    amount   = 6'(dim_span_log2) + 6'(FRAC_W);
    diff     = avg_ext - base_ext;
    if (avg_ext > base_ext) begin
      shifted = {diff, {DUTY_FRAC_BITS{1'b0}}} >> amount;
    end else begin
      shifted = '0;
    end
    low = (min_duty > DUTY_FULL) ? DUTY_FULL : min_duty;
    if (shifted > SH_W'(DUTY_FULL)) begin
      ramp = DUTY_FULL;
    end else if (shifted < SH_W'(low)) begin
      ramp = low;
    end else begin
      ramp = shifted[DUTY_W-1:0];
    end
  end

endmodule

>>> hdl/ambient_backlight_dimmer.sv
// Top level of the ambient backlight dimmer: sequencer, state and result register.
//
//   channel | direction | beat accepted when        | payload
//   in      | input     | in_valid && in_ready      | in_light_count
//   out     | output    | out_valid && out_ready    | out_backlight_on, out_duty_value,
//           |           |                           | out_drive_mode
//   cfg     | input     | cfg_valid && cfg_ready    | cfg_index, cfg_data
//
// A result is computed from its input beat by the light blend, the ramp state and, on the
// dimming ramp only, the duty blend; a forced duty (full or dark) skips the second blend.
// The time a result takes is set by the nine-step bit-serial weight multiply of the shared
// blend unit, run once for the light average and once more for the duty average. Samples
// are handled one at a time; the next beat is taken while the previous result still waits
// in the output register. Reset is synchronous and clears all averages, the hold counter
// and the enable. A stalled output only holds the sequencer in its final step, and
// cfg_ready is always high.
`timescale 1ns / 1ps

module ambient_backlight_dimmer #(
  parameter int unsigned COUNT_WIDTH    = abd_pkg::COUNT_WIDTH_DEF,
  parameter int unsigned DUTY_FRAC_BITS = abd_pkg::DUTY_FRAC_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [COUNT_WIDTH-1:0]         in_light_count,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           out_backlight_on,
  output logic [abd_pkg::DUTY_W-1:0]     out_duty_value,
  output logic [1:0]                     out_drive_mode,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [abd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [abd_pkg::CFG_DATA_W-1:0] cfg_data
);
  import abd_pkg::*;

  localparam int unsigned AVG_W    = COUNT_WIDTH + FRAC_W;
  localparam int unsigned EXT_W    = (AVG_W > 24) ? AVG_W : 24;
  localparam int unsigned FULL_INT = (DUTY_FRAC_BITS >= 16) ? 65535 : (1 << DUTY_FRAC_BITS);
  localparam logic [DUTY_W-1:0] DUTY_FULL = DUTY_W'(FULL_INT);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_AVG  = 5'b00010,
    ST_RAMP = 5'b00100,
    ST_DUTY = 5'b01000,
    ST_OUT  = 5'b10000
  } state_t;

  cfg_t cfg;

  state_t            state_r, state_nxt;
  logic [AVG_W-1:0]  light_avg_r, light_avg_nxt;
  logic [DUTY_W-1:0] duty_avg_r, duty_avg_nxt;
  logic [8:0]        bright_cnt_r, bright_cnt_nxt;
  logic              enabled_r, enabled_nxt;
  drive_mode_t       mode_r, mode_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic              out_on_r;
  logic [DUTY_W-1:0] out_duty_r;
  drive_mode_t       out_mode_r;
  logic              out_load;

  logic              blend_start, blend_done;
  logic [AVG_W-1:0]  blend_x, blend_old, blend_result;
  logic [DUTY_W-1:0] ramp;

  logic [EXT_W-1:0]  avg_ext;
  logic              is_bright, is_full;
  logic [8:0]        hold_top, cnt_inc;

  abd_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  abd_blend #(.AVG_W(AVG_W)) u_blend (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (blend_start),
    .x_in   (blend_x),
    .old_in (blend_old),
    .weight (cfg.smooth_weight),
    .done   (blend_done),
    .result (blend_result)
  );

  abd_ramp #(.AVG_W(AVG_W), .DUTY_FRAC_BITS(DUTY_FRAC_BITS)) u_ramp (
    .avg           (light_avg_r),
    .dim_offset    (cfg.dim_offset),
    .dim_span_log2 (cfg.dim_span_log2),
    .min_duty      (cfg.min_duty),
    .ramp          (ramp)
  );

  assign in_ready = (state_r == ST_IDLE);
  assign out_load = (state_r == ST_OUT) && (!out_valid_r || out_ready);

  always_comb begin
    avg_ext   = EXT_W'(light_avg_r);
    is_bright = avg_ext > EXT_W'({cfg.bright_limit, {FRAC_W{1'b0}}});
    is_full   = avg_ext > EXT_W'({cfg.full_limit, {FRAC_W{1'b0}}});
    hold_top  = {1'b0, cfg.bright_hold} + 9'd1;
    cnt_inc   = (bright_cnt_r < hold_top) ? bright_cnt_r + 9'd1 : bright_cnt_r;
  end

  // The blend unit is shared: the light average first, then the duty average.
  always_comb begin
    if (state_r == ST_IDLE) begin
      blend_x   = {in_light_count, {FRAC_W{1'b0}}};
      blend_old = light_avg_r;
    end else begin
      blend_x   = AVG_W'(ramp);
      blend_old = AVG_W'(duty_avg_r);
    end
  end

  always_comb begin
    state_nxt      = state_r;
    light_avg_nxt  = light_avg_r;
    duty_avg_nxt   = duty_avg_r;
    bright_cnt_nxt = bright_cnt_r;
    enabled_nxt    = enabled_r;
    mode_nxt       = mode_r;
    blend_start    = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          blend_start = 1'b1;
          state_nxt   = ST_AVG;
        end
      end
      ST_AVG: begin
        if (blend_done) begin
          light_avg_nxt = blend_result;
          state_nxt     = ST_RAMP;
        end
      end
      ST_RAMP: begin
        if (is_bright) begin
          bright_cnt_nxt = cnt_inc;
          if (cnt_inc > {1'b0, cfg.bright_hold}) begin
            enabled_nxt  = 1'b0;
            duty_avg_nxt = '0;
            mode_nxt     = MODE_DARK;
          end else begin
            duty_avg_nxt = DUTY_FULL;
            mode_nxt     = MODE_FULL;
          end
          state_nxt = ST_OUT;
        end else begin
          bright_cnt_nxt = '0;
          enabled_nxt    = 1'b1;
          if (is_full) begin
            duty_avg_nxt = DUTY_FULL;
            mode_nxt     = MODE_FULL;
            state_nxt    = ST_OUT;
          end else begin
            mode_nxt    = MODE_RAMP;
            blend_start = 1'b1;
            state_nxt   = ST_DUTY;
          end
        end
      end
      ST_DUTY: begin
        if (blend_done) begin
          duty_avg_nxt = blend_result[DUTY_W-1:0];
          state_nxt    = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      light_avg_r  <= '0;
      duty_avg_r   <= '0;
      bright_cnt_r <= '0;
      enabled_r    <= 1'b0;
      mode_r       <= MODE_RAMP;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      light_avg_r  <= light_avg_nxt;
      duty_avg_r   <= duty_avg_nxt;
      bright_cnt_r <= bright_cnt_nxt;
      enabled_r    <= enabled_nxt;
      mode_r       <= mode_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_on_r   <= enabled_r;
      out_duty_r <= duty_avg_r;
      out_mode_r <= mode_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_backlight_on = out_on_r;
  assign out_duty_value   = out_duty_r;
  assign out_drive_mode   = out_mode_r;

endmodule

>>> test/tb_ambient_backlight_dimmer.sv
// Self-checking testbench for the ambient backlight dimmer: a directed plan, then random phases.
`timescale 1ns / 1ps

module tb_ambient_backlight_dimmer;
  import abd_pkg::*;

  localparam int unsigned FRAC_BITS = DUTY_FRAC_BITS_DEF;
  localparam logic [63:0] DUTY_FULL =
    ((64'd1 << FRAC_BITS) > 64'd65535) ? 64'd65535 : (64'd1 << FRAC_BITS);
  localparam int SETTLE_CYCLES   = 40;
  localparam int PHASES          = 7;
  localparam int PHASE_SAMPLES   = 100;
  localparam int HOLD_OFF_AT     = 380;
  localparam int HOLD_OFF_CYCLES = 300;

  typedef struct packed {
    logic        lamp_on;
    logic [15:0] duty;
    drive_mode_t mode;
  } drive_t;

  typedef enum bit {ROW_WRITE, ROW_SAMPLE} row_kind_t;

  typedef struct {
    row_kind_t   kind;
    reg_idx_t    idx;
    logic [15:0] value;
    bit          pinned;
    drive_t      want;
  } plan_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [15:0] in_light_count = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        out_backlight_on;
  logic [15:0] out_duty_value;
  logic [1:0]  out_drive_mode;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  // Register shadows and predicted state of the dimmer.
  logic [15:0]         lim_bright   = RST_BRIGHT_LIMIT;
  logic [15:0]         lim_full     = RST_FULL_LIMIT;
  logic [15:0]         ramp_offset  = RST_DIM_OFFSET;
  logic [SPAN_W-1:0]   ramp_span    = RST_DIM_SPAN_LOG2;
  logic [DUTY_W-1:0]   duty_floor   = RST_MIN_DUTY;
  logic [HOLD_W-1:0]   hold_len     = RST_BRIGHT_HOLD;
  logic [WEIGHT_W-1:0] blend_w      = RST_SMOOTH_WEIGHT;
  logic [23:0]         avg_light    = '0;
  logic [15:0]         avg_duty     = '0;
  logic [8:0]          bright_run   = '0;
  logic                lamp_enabled = 1'b0;

  drive_t    pending_drive[$];
  plan_row_t plan[$];

  int  failures = 0;
  int  samples_fed = 0;
  int  directed_samples = 0;
  int  writes_done = 0;
  int  results_seen = 0;
  int  ramp_seen = 0;
  int  full_seen = 0;
  int  dark_seen = 0;
  bit  settle_due = 1'b0;
  bit  no_idle = 1'b0;
  bit  hold_off_armed = 1'b1;

  ambient_backlight_dimmer i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_light_count   (in_light_count),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_backlight_on (out_backlight_on),
    .out_duty_value   (out_duty_value),
    .out_drive_mode   (out_drive_mode),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (no_idle || roll < 50) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Exponential average step, rounding half up; weights above 256 saturate.
  function automatic logic [63:0] ema_blend(input logic [63:0] fresh, input logic [63:0] prior);
    logic [63:0] w;
    w = (blend_w > 9'd256) ? 64'd256 : 64'(blend_w);
    return (fresh * w + prior * (64'd256 - w) + 64'd128) >> 8;
  endfunction

  function automatic drive_t dimmer_step(input logic [15:0] count);
    logic [63:0] mix;
    logic [63:0] base;
    logic [63:0] ramp;
    logic [63:0] floor_v;
    drive_t      res;
    mix = ema_blend(64'(count) << 8, 64'(avg_light));
    avg_light = mix[23:0];
    if (64'(avg_light) > (64'(lim_bright) << 8)) begin
      if (bright_run < 9'(hold_len) + 9'd1) bright_run = bright_run + 9'd1;
      if (bright_run > 9'(hold_len)) begin
        lamp_enabled = 1'b0;
        avg_duty = '0;
        res.mode = MODE_DARK;
      end else begin
        avg_duty = DUTY_FULL[15:0];
        res.mode = MODE_FULL;
      end
    end else begin
      bright_run = '0;
      if (64'(avg_light) > (64'(lim_full) << 8)) begin
        avg_duty = DUTY_FULL[15:0];
        res.mode = MODE_FULL;
      end else begin
        base = 64'(ramp_offset) << 8;
        ramp = '0;
        floor_v = (64'(duty_floor) > DUTY_FULL) ? DUTY_FULL : 64'(duty_floor);
        if (64'(avg_light) > base)
          ramp = ((64'(avg_light) - base) << FRAC_BITS) >> (64'(ramp_span) + 64'd8);
        if (ramp > DUTY_FULL) ramp = DUTY_FULL;
        else if (ramp < floor_v) ramp = floor_v;
        mix = ema_blend(ramp, 64'(avg_duty));
        avg_duty = mix[15:0];
        res.mode = MODE_RAMP;
      end
      lamp_enabled = 1'b1;
    end
    res.lamp_on = lamp_enabled;
    res.duty = avg_duty;
    return res;
  endfunction

  function automatic void plan_write(input reg_idx_t idx, input logic [15:0] value);
    plan.push_back('{ROW_WRITE, idx, value, 1'b0, '0});
  endfunction

  function automatic void plan_sample(input logic [15:0] count);
    plan.push_back('{ROW_SAMPLE, REG_BRIGHT_LIMIT, count, 1'b0, '0});
  endfunction

  function automatic void plan_pinned(input logic [15:0] count, input logic lamp_on,
                                      input logic [15:0] duty, input drive_mode_t mode);
    drive_t want;
    want.lamp_on = lamp_on;
    want.duty = duty;
    want.mode = mode;
    plan.push_back('{ROW_SAMPLE, REG_BRIGHT_LIMIT, count, 1'b1, want});
  endfunction

  // Lets the block finish and go quiet so that registers may be changed.
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_drive.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    settle_due = 1'b0;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_drive.size() != 0);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [15:0] value);
    if (settle_due) settle();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_BRIGHT_LIMIT:  lim_bright  = value;
      REG_FULL_LIMIT:    lim_full    = value;
      REG_DIM_OFFSET:    ramp_offset = value;
      REG_DIM_SPAN_LOG2: ramp_span   = value[SPAN_W-1:0];
      REG_MIN_DUTY:      duty_floor  = value;
      REG_BRIGHT_HOLD:   hold_len    = value[HOLD_W-1:0];
      REG_SMOOTH_WEIGHT: blend_w     = value[WEIGHT_W-1:0];
      default: ;
    endcase
    writes_done++;
  endtask

  task automatic feed_sample(input logic [15:0] count, input bit pinned, input drive_t literal);
    drive_t predicted;
    int     gap;
    cfg_valid      <= 1'b0;
    in_valid       <= 1'b1;
    in_light_count <= count;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predicted = dimmer_step(count);
    pending_drive.push_back(pinned ? literal : predicted);
    samples_fed++;
    settle_due = 1'b1;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic take_result();
    drive_t want;
    results_seen++;
    case (out_drive_mode)
      MODE_RAMP: ramp_seen++;
      MODE_FULL: full_seen++;
      MODE_DARK: dark_seen++;
      default: ;
    endcase
    if (pending_drive.size() == 0) begin
      $error("result beat arrived with no sample outstanding");
      failures++;
    end else begin
      want = pending_drive.pop_front();
      if (out_backlight_on !== want.lamp_on) begin
        $error("out_backlight_on: expected %0d, got %0d", want.lamp_on, out_backlight_on);
        failures++;
      end
      if (out_duty_value !== want.duty) begin
        $error("out_duty_value: expected %0d, got %0d", want.duty, out_duty_value);
        failures++;
      end
      if (out_drive_mode !== want.mode) begin
        $error("out_drive_mode: expected %0d, got %0d", want.mode, out_drive_mode);
        failures++;
      end
    end
  endtask

  // Result side: random stalls, plus one long hold-off that backs the block up.
  initial begin : result_sink
    int stall_left;
    int held;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) take_result();
      if (hold_off_armed && results_seen == HOLD_OFF_AT) begin
        hold_off_armed = 1'b0;
        out_ready <= 1'b0;
        for (held = 0; held < HOLD_OFF_CYCLES; held++) @(posedge clk);
      end
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= 1'b1;
        stall_left = pick_gap();
      end
    end
  end

  initial begin : watchdog
    #2_000_000;
    $error("run did not complete in the time allowed");
    $display("Some tests failed");
    $finish;
  end

  initial begin : stimulus
    int phase;
    int n;
    int k;
    int run_len;
    int level;
    int count;

    // Weight 256 makes each average follow its input at once, so the
    // pinned rows can be read straight off the rules.
    plan_sample(16'd0);
    plan_write(REG_SMOOTH_WEIGHT, 16'd256);
    plan_pinned(16'd0, 1'b1, 16'd2621, MODE_RAMP);
    plan_pinned(16'hFFFF, 1'b1, 16'd32768, MODE_FULL);
    plan_write(REG_BRIGHT_HOLD, 16'd0);
    plan_pinned(16'hFFFF, 1'b0, 16'd0, MODE_DARK);
    plan_pinned(16'hFFFF, 1'b0, 16'd0, MODE_DARK);
    plan_pinned(16'd0, 1'b1, 16'd2621, MODE_RAMP);
    plan_write(REG_BRIGHT_HOLD, 16'd255);
    plan_sample(16'd1280);
    plan_pinned(16'd1281, 1'b1, 16'd32768, MODE_FULL);
    // A floor above full duty is held at full duty.
    plan_write(REG_MIN_DUTY, 16'hFFFF);
    plan_pinned(16'd0, 1'b1, 16'd32768, MODE_RAMP);
    plan_write(REG_MIN_DUTY, 16'd0);
    plan_write(REG_DIM_SPAN_LOG2, 16'd31);
    plan_sample(16'd1000);
    plan_write(REG_DIM_SPAN_LOG2, 16'd0);
    plan_sample(16'd200);
    plan_write(REG_DIM_OFFSET, 16'hFFFF);
    plan_sample(16'd1200);
    plan_write(REG_DIM_OFFSET, 16'd0);
    plan_write(REG_DIM_SPAN_LOG2, 16'd7);
    plan_write(REG_SMOOTH_WEIGHT, 16'hFFFF);
    plan_sample(16'd300);
    plan_write(REG_SMOOTH_WEIGHT, 16'd0);
    plan_sample(16'hFFFF);
    plan_sample(16'd12345);
    plan_write(REG_SMOOTH_WEIGHT, 16'd1);
    plan_sample(16'hFFFF);
    plan_write(REG_SMOOTH_WEIGHT, 16'd256);
    plan_write(REG_BRIGHT_LIMIT, 16'hFFFF);
    plan_write(REG_FULL_LIMIT, 16'hFFFF);
    plan_sample(16'hFFFF);
    plan_write(REG_BRIGHT_LIMIT, 16'd0);
    plan_write(REG_FULL_LIMIT, 16'd0);
    plan_sample(16'd0);
    plan_sample(16'd1);

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_WRITE) write_reg(plan[i].idx, plan[i].value);
      else feed_sample(plan[i].value, plan[i].pinned, plan[i].want);
    end
    directed_samples = samples_fed;

    for (phase = 0; phase < PHASES; phase++) begin
      case ($urandom_range(0, 3))
        0: write_reg(REG_BRIGHT_LIMIT, 16'd0);
        1: write_reg(REG_BRIGHT_LIMIT, 16'hFFFF);
        2: write_reg(REG_BRIGHT_LIMIT, 16'($urandom_range(0, 65535)));
        default: write_reg(REG_BRIGHT_LIMIT, 16'($urandom_range(1000, 40000)));
      endcase
      case ($urandom_range(0, 3))
        0: write_reg(REG_FULL_LIMIT, 16'd0);
        1: write_reg(REG_FULL_LIMIT, 16'hFFFF);
        2: write_reg(REG_FULL_LIMIT, 16'($urandom_range(0, 65535)));
        default: write_reg(REG_FULL_LIMIT, 16'($urandom_range(200, 5000)));
      endcase
      case ($urandom_range(0, 3))
        0: write_reg(REG_DIM_OFFSET, 16'd0);
        1: write_reg(REG_DIM_OFFSET, 16'hFFFF);
        2: write_reg(REG_DIM_OFFSET, 16'($urandom_range(0, 65535)));
        default: write_reg(REG_DIM_OFFSET, 16'($urandom_range(0, 2000)));
      endcase
      if ($urandom_range(0, 3) == 0)
        write_reg(REG_DIM_SPAN_LOG2, 16'($urandom_range(0, 65535)));
      else
        write_reg(REG_DIM_SPAN_LOG2, 16'($urandom_range(7, 16)));
      case ($urandom_range(0, 3))
        0: write_reg(REG_MIN_DUTY, 16'd0);
        1: write_reg(REG_MIN_DUTY, 16'd32768);
        2: write_reg(REG_MIN_DUTY, 16'($urandom_range(0, 65535)));
        default: write_reg(REG_MIN_DUTY, 16'($urandom_range(0, 32768)));
      endcase
      case ($urandom_range(0, 3))
        0: write_reg(REG_BRIGHT_HOLD, 16'd0);
        1: write_reg(REG_BRIGHT_HOLD, 16'($urandom_range(0, 65535)));
        default: write_reg(REG_BRIGHT_HOLD, 16'($urandom_range(0, 40)));
      endcase
      case ($urandom_range(0, 7))
        0: write_reg(REG_SMOOTH_WEIGHT, 16'd0);
        1: write_reg(REG_SMOOTH_WEIGHT, 16'd256);
        2: write_reg(REG_SMOOTH_WEIGHT, 16'($urandom_range(0, 65535)));
        default: write_reg(REG_SMOOTH_WEIGHT, 16'($urandom_range(16, 256)));
      endcase
      no_idle = (phase == 2);

      // Mostly runs held near one level, so that the average settles and the
      // hold counter can run out; the rest is scattered noise.
      n = 0;
      while (n < PHASE_SAMPLES) begin
        if ($urandom_range(0, 7) == 0) begin
          feed_sample(16'($urandom_range(0, 65535)), 1'b0, '0);
          n++;
        end else begin
          case ($urandom_range(0, 6))
            0: level = 0;
            1: level = 65535;
            2: level = lim_bright;
            3: level = lim_full;
            4: level = ramp_offset + $urandom_range(0, 1024);
            5: level = $urandom_range(0, 65535);
            default: level = $urandom_range(0, 4000);
          endcase
          run_len = $urandom_range(4, 40);
          for (k = 0; k < run_len && n < PHASE_SAMPLES; k++) begin
            count = level + $urandom_range(0, 8) - 4;
            if (count < 0) count = 0;
            if (count > 65535) count = 65535;
            feed_sample(16'(count), 1'b0, '0);
            n++;
          end
        end
        if ($urandom_range(0, 49) == 0) wait_drained();
      end
    end

    in_valid <= 1'b0;
    while (pending_drive.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Fed %0d light samples (%0d directed) with %0d register writes over %0d phases.",
             samples_fed, directed_samples, writes_done, PHASES);
    $display("Drive modes returned: ramp %0d, full %0d, dark %0d.",
             ramp_seen, full_seen, dark_seen);
    if (failures == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

>>> ambient_backlight_dimmer.f
hdl/abd_pkg.sv
hdl/abd_cfg_regs.sv
hdl/abd_blend.sv
hdl/abd_ramp.sv
hdl/ambient_backlight_dimmer.sv
test/tb_ambient_backlight_dimmer.sv
